// File: design/integer_to_ascii_formatter_macros.svh
// Assertion macros used by the formatter design file.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Check that a condition implies another in the same cycle
`define I2A_ASSERT_SAME(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("i2a: same-cycle check failed");

// Check that a condition implies another in the following cycle
`define I2A_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("i2a: next-cycle check failed");

`endif

// File: design/i2a_pkg.sv
// Package with widths, codes, characters and helpers for the formatter.
`timescale 1ns / 1ps
package i2a_pkg;

	localparam int VALUE_W  = 64;
	localparam int NARROW_W = 32;
	localparam int OPCODE_W = 2;
	localparam int CHAR_W   = 8;
	localparam int COUNT_W  = 5;
	localparam int NIB_W    = 4;
	localparam int DIGITS   = 20;
	localparam int DIG_W    = DIGITS * NIB_W;
	localparam int STEPS    = VALUE_W;
	localparam int STEP_W   = $clog2(STEPS);

	// Opcode fields
	localparam int OP_WIDE_BIT = 0;
	localparam int OP_HEX_BIT  = 1;
	localparam logic [OPCODE_W-1:0] OP_DEC32 = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_DEC64 = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_HEX32 = 2'd2;
	localparam logic [OPCODE_W-1:0] OP_HEX64 = 2'd3;

	// Characters
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_X    = 8'h78;

	localparam logic [NIB_W-1:0] DEC_BASE  = 4'd10;
	localparam logic [NIB_W-1:0] DAB_LIMIT = 4'd5;
	localparam logic [NIB_W-1:0] DAB_ADD   = 4'd3;

	// Map one digit to its lower-case ASCII character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [NIB_W-1:0] d);
		logic [CHAR_W-1:0] dw;
		dw = {{(CHAR_W-NIB_W){1'b0}}, d};
		if (d < DEC_BASE) begin
			return CH_ZERO + dw;
		end
		return CH_A + dw - {{(CHAR_W-NIB_W){1'b0}}, DEC_BASE};
	endfunction

endpackage

// File: design/i2a_if.sv
// Handshake interfaces for the formatter input and character output channels.
`timescale 1ns / 1ps
interface i2a_in_if import i2a_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  value;
	logic [OPCODE_W-1:0] opcode;

	modport source (output valid, output value, output opcode, input ready);
	modport sink (input valid, input value, input opcode, output ready);
endinterface

interface i2a_out_if import i2a_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CHAR_W-1:0]  character;
	logic               last;
	logic [COUNT_W-1:0] digit_count;

	modport source (output valid, output character, output last, output digit_count,
		input ready);
	modport sink (input valid, input character, input last, input digit_count,
		output ready);
endinterface

// File: design/integer_to_ascii_formatter.sv
// Integer to ASCII formatter: shift-and-adjust converter with a character sequencer.
//
// Takes one number at a time (value, opcode) and emits its text one character per
// output transfer, most significant digit first, leading zeros dropped; hex gets a
// "0x" prefix unless the value is zero, and the last character carries the digit
// count. The input is ready only while the sequencer is idle. Decimal items go
// through the shared shift-and-add-3 unit, one bit per step over all 64 bits
// whatever the width, hex items load their nibbles directly. A leading-zero strip
// then drops up to 19 digits and hands over to the output, and the characters
// leave at one per cycle when the sink keeps ready high. The output register lets
// the next item be taken while the final character still waits for its transfer.
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_macros.svh"
module integer_to_ascii_formatter import i2a_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	i2a_in_if.sink     din,
	i2a_out_if.source  dout
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CONV = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_PRE0 = 3'd3;
	localparam logic [2:0] ST_PREX = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	logic [2:0]         state_q;
	logic               hex_q;
	logic               zero_q;
	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] n_q;
	logic [COUNT_W-1:0] rem_q;
	logic [DIG_W-1:0]   dig_q;
	logic [VALUE_W-1:0] sh_q;

	logic               out_valid_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;
	logic [COUNT_W-1:0] count_q;

	logic [VALUE_W-1:0] masked;
	logic [DIG_W-1:0]   adj;
	logic [DIG_W-1:0]   dab;
	logic [NIB_W-1:0]   top;
	logic               out_free;
	logic               emit_go;

	// Drop the upper half of the value in the narrow modes
	assign masked = din.opcode[OP_WIDE_BIT] ? din.value
		: {{(VALUE_W-NARROW_W){1'b0}}, din.value[NARROW_W-1:0]};

	// Shared converter step: add 3 to every digit of 5 or more, then shift one bit in
	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (dig_q[i*NIB_W +: NIB_W] >= DAB_LIMIT) begin
				adj[i*NIB_W +: NIB_W] = dig_q[i*NIB_W +: NIB_W] + DAB_ADD;
			end else begin
				adj[i*NIB_W +: NIB_W] = dig_q[i*NIB_W +: NIB_W];
			end
		end
		dab = {adj[DIG_W-2:0], sh_q[VALUE_W-1]};
	end

	assign top      = dig_q[DIG_W-1 -: NIB_W];
	assign out_free = !out_valid_q || dout.ready;
	assign emit_go  = out_free
		&& (state_q == ST_PRE0 || state_q == ST_PREX || state_q == ST_EMIT);

	// Hold a character until its transfer, load the next one as the slot frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Sequencer, digit register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (din.valid) begin
						hex_q  <= din.opcode[OP_HEX_BIT];
						zero_q <= (masked == '0);
						step_q <= '0;
						n_q    <= COUNT_W'(DIGITS);
						if (din.opcode[OP_HEX_BIT]) begin
							dig_q   <= {{(DIG_W-VALUE_W){1'b0}}, masked};
							state_q <= ST_NORM;
						end else begin
							dig_q   <= '0;
							sh_q    <= masked;
							state_q <= ST_CONV;
						end
					end
				end
				ST_CONV: begin
					dig_q  <= dab;
					sh_q   <= {sh_q[VALUE_W-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(STEPS - 1)) begin
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					// Strip one leading zero digit a cycle, keep at least one digit
					if (n_q > COUNT_W'(1) && top == '0) begin
						dig_q <= {dig_q[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
						n_q   <= n_q - 1'b1;
					end else begin
						rem_q   <= n_q;
						state_q <= (hex_q && !zero_q) ? ST_PRE0 : ST_EMIT;
					end
				end
				ST_PRE0: begin
					if (out_free) begin
						char_q      <= CH_ZERO;
						last_q      <= 1'b0;
						count_q     <= '0;
						state_q     <= ST_PREX;
					end
				end
				ST_PREX: begin
					if (out_free) begin
						char_q      <= CH_X;
						last_q      <= 1'b0;
						count_q     <= '0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						char_q      <= digit_char(top);
						last_q      <= (rem_q == COUNT_W'(1));
						count_q     <= (rem_q == COUNT_W'(1)) ? n_q : '0;
						dig_q       <= {dig_q[DIG_W-NIB_W-1:0], {NIB_W{1'b0}}};
						rem_q       <= rem_q - 1'b1;
						if (rem_q == COUNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign din.ready        = (state_q == ST_IDLE);
	assign dout.valid       = out_valid_q;
	assign dout.character   = char_q;
	assign dout.last        = last_q;
	assign dout.digit_count = count_q;

	// Checks on the sequencer and the emitted stream
	`I2A_ASSERT_SAME(a_last_has_count, clk, arst_n, dout.valid && dout.last, dout.digit_count != '0)
	`I2A_ASSERT_SAME(a_mid_no_count, clk, arst_n, dout.valid && !dout.last, dout.digit_count == '0)
	`I2A_ASSERT_NEXT(a_accept_busy, clk, arst_n, din.valid && din.ready, state_q != ST_IDLE)
	`I2A_ASSERT_SAME(a_emit_remaining, clk, arst_n, state_q == ST_EMIT, rem_q != '0 && rem_q <= n_q)

endmodule

// File: dv/integer_to_ascii_formatter_tb.sv
// Self-checking testbench for the integer to ASCII formatter.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_tb;
	import i2a_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 7;
	localparam int RANDOM_NUMBERS = 448;
	localparam int STALL_LIMIT    = 3000;
	localparam int DRAIN_CYCLES   = 100;
	localparam logic [VALUE_W-1:0] RADIX_DEC = 64'd10;
	localparam logic [VALUE_W-1:0] RADIX_HEX = 64'd16;
	localparam logic [VALUE_W-1:0] ALL_ONES  = {VALUE_W{1'b1}};

	typedef struct packed {
		logic [CHAR_W-1:0]  character;
		logic               last;
		logic [COUNT_W-1:0] digit_count;
	} char_item_t;

	// Expected text of every accepted number, one entry per character
	class text_scoreboard;
		char_item_t pending_chars[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		// Work out the characters that one accepted number must produce
		function void note_number(logic [VALUE_W-1:0] value, logic [OPCODE_W-1:0] opcode);
			logic [VALUE_W-1:0] rest;
			logic [VALUE_W-1:0] digit;
			logic [CHAR_W-1:0]  digit_chars[$];
			bit                 hex;
			int                 n;
			hex  = opcode[OP_HEX_BIT];
			rest = opcode[OP_WIDE_BIT] ? value
				: {{(VALUE_W-NARROW_W){1'b0}}, value[NARROW_W-1:0]};
			// zero prints a bare digit, never a prefix
			if (rest == '0) begin
				pending_chars.push_back('{CH_ZERO, 1'b1, COUNT_W'(1)});
				return;
			end
			// collect digits least significant first
			while (rest != '0) begin
				digit = rest % (hex ? RADIX_HEX : RADIX_DEC);
				rest  = rest / (hex ? RADIX_HEX : RADIX_DEC);
				if (digit < RADIX_DEC)
					digit_chars.push_back(CH_ZERO + digit[CHAR_W-1:0]);
				else
					digit_chars.push_back(CH_A + digit[CHAR_W-1:0] - RADIX_DEC[CHAR_W-1:0]);
			end
			n = digit_chars.size();
			if (hex) begin
				pending_chars.push_back('{CH_ZERO, 1'b0, COUNT_W'(0)});
				pending_chars.push_back('{CH_X, 1'b0, COUNT_W'(0)});
			end
			for (int i = n - 1; i >= 0; i--) begin
				pending_chars.push_back('{digit_chars[i], i == 0, (i == 0) ? COUNT_W'(n) : COUNT_W'(0)});
			end
		endfunction

		// Compare one transferred character with the oldest expectation
		function void check_char(char_item_t got);
			char_item_t want;
			if (pending_chars.size() == 0) begin
				$error("unexpected character %0h, nothing outstanding", got.character);
				errors++;
				return;
			end
			want = pending_chars.pop_front();
			if (got.character !== want.character) begin
				$error("character: expected %0h, actual %0h", want.character, got.character);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0d, actual %0d", want.last, got.last);
				errors++;
			end
			if (got.digit_count !== want.digit_count) begin
				$error("digit_count: expected %0d, actual %0d", want.digit_count,
					got.digit_count);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	int   stall_cycles;

	text_scoreboard sb;

	i2a_in_if  din ();
	i2a_out_if dout ();

	integer_to_ascii_formatter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din.sink),
		.dout   (dout.source)
	);

	always #HALF_PERIOD clk = ~clk;

	// Throttle the character sink at random
	always @(posedge clk) begin
		dout.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Record accepted numbers and check transferred characters
	always @(posedge clk) begin
		if (arst_n) begin
			if (din.valid && din.ready)
				sb.note_number(din.value, din.opcode);
			if (dout.valid && dout.ready)
				sb.check_char('{dout.character, dout.last, dout.digit_count});
		end
	end

	// Abort when no transfer has happened for too long
	always @(posedge clk) begin
		if (!arst_n || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Offer one number and hold it until the block takes it
	task automatic send_number(logic [VALUE_W-1:0] value, logic [OPCODE_W-1:0] opcode);
		while ($urandom_range(99) < tx_idle_pct) begin
			din.valid <= 1'b0;
			@(posedge clk);
		end
		din.valid  <= 1'b1;
		din.value  <= value;
		din.opcode <= opcode;
		@(posedge clk);
		while (!din.ready) @(posedge clk);
	endtask

	// Pick a random number with a spread of digit counts
	function automatic logic [VALUE_W-1:0] random_number();
		logic [VALUE_W-1:0] full;
		full = {$urandom, $urandom};
		case ($urandom_range(9))
			0, 1, 2, 3: return full;
			4, 5, 6:    return full >> $urandom_range(VALUE_W - 1);
			7:          return VALUE_W'($urandom_range(20));
			8:          return ALL_ONES >> $urandom_range(VALUE_W - 1);
			default:    return full & (ALL_ONES << $urandom_range(VALUE_W - 1));
		endcase
	endfunction

	initial begin
		logic [VALUE_W-1:0] edge_values[$];
		clk          = 1'b0;
		arst_n       = 1'b0;
		stall_cycles = 0;
		din.valid    = 1'b0;
		din.value    = '0;
		din.opcode   = OP_DEC32;
		dout.ready   = 1'b0;
		tx_idle_pct  = 36;
		rx_idle_pct  = 84;
		sb           = new();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero, high half only, one-digit to full-width values, every opcode
		edge_values = '{64'd0, 64'hffff_ffff_0000_0000, ALL_ONES, 64'h0000_0000_ffff_ffff,
			64'd1};
		foreach (edge_values[i]) begin
			send_number(edge_values[i], OP_DEC32);
			send_number(edge_values[i], OP_DEC64);
			send_number(edge_values[i], OP_HEX32);
			send_number(edge_values[i], OP_HEX64);
		end
		send_number(64'd9, OP_DEC32);
		send_number(64'd10, OP_DEC32);
		send_number(64'd15, OP_HEX32);
		send_number(64'd16, OP_HEX32);
		send_number(64'd10_000_000_000_000_000_000, OP_DEC64);
		send_number(64'h8000_0000_0000_0000, OP_HEX64);
		send_number(64'h0123_4567_89ab_cdef, OP_HEX64);
		send_number(64'hfedc_ba98_7654_3210, OP_DEC64);

		// Random numbers across three idling phases
		for (int k = 0; k < RANDOM_NUMBERS; k++) begin
			if (k == RANDOM_NUMBERS / 3) begin
				tx_idle_pct = 84;
				rx_idle_pct = 36;
			end else if (k == 2 * RANDOM_NUMBERS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			send_number(random_number(), OP_DEC32 + OPCODE_W'($urandom_range(3)));
		end
		din.valid <= 1'b0;

		// Drain outstanding characters, then watch for strays
		while (sb.pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pending_chars.size() != 0) begin
			$error("%0d characters never arrived", sb.pending_chars.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+design
design/i2a_pkg.sv
design/i2a_if.sv
design/integer_to_ascii_formatter.sv
dv/integer_to_ascii_formatter_tb.sv
